// ===== sv/deq_pkg.sv =====
// shared types and constants for the double-ended queue
// no dependencies; used by deq_ctrl and double_ended_queue
`timescale 1ns / 1ps

package deq_pkg;

    localparam int WORD_W   = 32;
    localparam int CNT_W    = 11;
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 3;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-beat outcome handed from the pointer logic to the output side
    typedef struct packed {
        logic               pop_ok;
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic               empty;
        logic               full;
    } t_step_info;

endpackage

// ===== sv/double_ended_queue.sv =====
// top level of the double-ended queue: stream ports, pending stage, output register
// depends on deq_pkg, deq_ctrl and deq_ram
`timescale 1ns / 1ps

// usage
//   slave channel: one beat is one request. tuser carries the action
//   (push front, push back, pop front, pop back); tdata the word to push.
//   master channel: one result beat per request, in request order.
//   pointer and count updates happen at the accepting edge; the ram access
//   (write for a push, read for a pop) is issued in the same cycle.
//   a result reaches the master side through the pending stage and the output
//   register. throughput: one request per cycle while the master side keeps
//   tready high; the registered ram read sets the pending stage between the two.
//   a push followed by a pop of the same slot next cycle reads the new word,
//   since the write lands at the edge before the read.
//   stall: with the output register full and tready low, one more request is
//   taken into the pending stage, its read data held in the ram output register;
//   then tready on the slave side drops until the master side drains.
//   reset: synchronous, active low; clears pointers, count and all valid flags.
//   the word store itself is not cleared, there is no clearing pass.
//   status: done, pop on empty ignored, or push on full dropped.

module double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [deq_pkg::S_DATA_W-1:0]   i_s_tdata,   // [31:0] push_value
    input  logic [deq_pkg::S_USER_W-1:0]   i_s_tuser,   // [1:0] action
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] taken_value, [42:32] entry_count, [43] is_empty, [44] is_full, [47:45] zero
    output logic [deq_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic [deq_pkg::M_USER_W-1:0]   o_m_tuser    // [0] taken_valid, [2:1] status
);

    localparam int AW = $clog2(DEPTH);

    logic                          s_accept;
    logic                          move;
    logic [AW-1:0]                 ram_addr;
    logic                          ram_we;
    logic                          ram_re;
    logic [deq_pkg::WORD_W-1:0]    ram_rdata;
    deq_pkg::t_step_info           step_info;
    logic [deq_pkg::WORD_W-1:0]    taken;

    logic                          r_busy;
    deq_pkg::t_step_info           r_pend;
    logic                          r_out_valid;
    logic [deq_pkg::M_DATA_W-1:0]  r_out_data;
    logic [deq_pkg::M_USER_W-1:0]  r_out_user;

    // pending beat advances when the output register is free or draining
    assign move       = r_busy && (!r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_busy || move);
    assign s_accept   = i_s_tvalid && o_s_tready;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_action (deq_pkg::t_action'(i_s_tuser[1:0])),
        .o_addr   (ram_addr),
        .o_we     (ram_we),
        .o_re     (ram_re),
        .o_info   (step_info)
    );

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_s_tdata[deq_pkg::WORD_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign taken = r_pend.pop_ok ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_busy <= 1'b1;
                r_pend <= step_info;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {3'b000, r_pend.full, r_pend.empty, r_pend.count, taken};
                r_out_user  <= {r_pend.status, r_pend.pop_ok};
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

`ifndef ASSERT_OFF
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !move |=> r_busy && $stable(r_pend))
        else $error("pending beat lost while output stalled");

    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user[0] |-> r_out_user[2:1] == deq_pkg::ST_DONE)
        else $error("word taken with a failure status");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_user[2:1] == deq_pkg::ST_EMPTY |-> r_out_data[43])
        else $error("pop on empty reported with a non-empty queue");

    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[43] && r_out_data[44]))
        else $error("queue flagged empty and full at once");

    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("pending beat not moved to output");
`endif

endmodule

// ===== sv/deq_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/deq_ctrl.sv =====
// front/back pointers, entry count and ram access generation
// depends on deq_pkg
`timescale 1ns / 1ps

module deq_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  deq_pkg::t_action         i_action,
    output logic [$clog2(DEPTH)-1:0] o_addr,
    output logic                     o_we,
    output logic                     o_re,
    output deq_pkg::t_step_info      o_info
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back,  n_back;
    logic [CW-1:0] r_count, n_count;
    logic          is_full_now;
    logic          is_empty_now;
    logic [CW+deq_pkg::CNT_W-1:0] count_wide;

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        slot_next = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        slot_prev = (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    assign is_full_now  = (r_count == CW'(DEPTH));
    assign is_empty_now = (r_count == '0);

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        o_addr  = r_back;
        o_we    = 1'b0;
        o_re    = 1'b0;
        o_info.pop_ok = 1'b0;
        o_info.status = deq_pkg::ST_DONE;
        unique case (i_action)
            deq_pkg::ACT_PUSH_FRONT: begin
                if (is_full_now) begin
                    o_info.status = deq_pkg::ST_FULL;
                end else begin
                    n_front = slot_prev(r_front);
                    o_addr  = n_front;
                    o_we    = i_accept;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::ACT_PUSH_BACK: begin
                if (is_full_now) begin
                    o_info.status = deq_pkg::ST_FULL;
                end else begin
                    o_addr  = r_back;
                    o_we    = i_accept;
                    n_back  = slot_next(r_back);
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::ACT_POP_FRONT: begin
                if (is_empty_now) begin
                    o_info.status = deq_pkg::ST_EMPTY;
                end else begin
                    o_addr  = r_front;
                    o_re    = i_accept;
                    n_front = slot_next(r_front);
                    n_count = r_count - CW'(1);
                    o_info.pop_ok = 1'b1;
                end
            end
            deq_pkg::ACT_POP_BACK: begin
                if (is_empty_now) begin
                    o_info.status = deq_pkg::ST_EMPTY;
                end else begin
                    n_back  = slot_prev(r_back);
                    o_addr  = n_back;
                    o_re    = i_accept;
                    n_count = r_count - CW'(1);
                    o_info.pop_ok = 1'b1;
                end
            end
            default: begin
                o_info.status = deq_pkg::ST_DONE;
            end
        endcase
        // count shown masked to the field width
        count_wide   = (CW + deq_pkg::CNT_W)'(n_count);
        o_info.count = count_wide[deq_pkg::CNT_W-1:0];
        o_info.empty = (n_count == '0);
        o_info.full  = (n_count == CW'(DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_ram_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("ram read and write in one beat");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_we |=> r_count == $past(r_count) + CW'(1))
        else $error("count not bumped after a push");
`endif

endmodule
